FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

  // Command codes on the input side
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_WAIT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT    = 1'b1;

  localparam logic [13:0] TICKS_RESET   = 14'd8;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd250;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_WAIT  = 3'd4,
    KIND_READ  = 3'd5
  } kind_t;

  // One tick after classification
  typedef struct packed {
    kind_t      kind;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [16:0] {
    PH_IDLE    = 17'b00000000000000001,
    PH_ST_A    = 17'b00000000000000010,
    PH_ST_B    = 17'b00000000000000100,
    PH_SP_A    = 17'b00000000000001000,
    PH_SP_B    = 17'b00000000000010000,
    PH_WR_SET  = 17'b00000000000100000,
    PH_WR_HI   = 17'b00000000001000000,
    PH_WR_LO   = 17'b00000000010000000,
    PH_WA_REL  = 17'b00000000100000000,
    PH_WA_HI   = 17'b00000001000000000,
    PH_WA_POLL = 17'b00000010000000000,
    PH_TO_A    = 17'b00000100000000000,
    PH_TO_B    = 17'b00001000000000000,
    PH_RD_LO   = 17'b00010000000000000,
    PH_RD_HI   = 17'b00100000000000000,
    PH_RK_SET  = 17'b01000000000000000,
    PH_RK_HI   = 17'b10000000000000000
  } phase_t;

endpackage

FILE: hw/rtl/i2cm_queue.sv
module i2cm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2cm_pkg::item_t     push_item,
  input  logic                pop,
  output i2cm_pkg::item_t     pop_item,
  output i2cm_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  i2cm_pkg::item_t  slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_item     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/i2cm_front.sv
module i2cm_front (
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2cm_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [i2cm_pkg::IN_USER_W-1:0]      in_tuser,
  input  i2cm_pkg::q_status_t                 q_status,
  output logic                                push,
  output i2cm_pkg::item_t                     push_item
);

  logic       cmd_valid;
  logic [2:0] command;

  assign cmd_valid = in_tuser[0];
  assign command   = in_tuser[3:1];

  assign in_tready = !q_status.full;
  assign push      = in_tvalid && !q_status.full;

  always_comb begin
    push_item.write_data = in_tdata[7:0];
    push_item.send_ack   = in_tdata[8];
    push_item.sda_level  = in_tdata[9];
    push_item.kind       = i2cm_pkg::KIND_NONE;
    if (cmd_valid) begin
      unique case (command)
        i2cm_pkg::CMD_START: push_item.kind = i2cm_pkg::KIND_START;
        i2cm_pkg::CMD_STOP:  push_item.kind = i2cm_pkg::KIND_STOP;
        i2cm_pkg::CMD_WRITE: push_item.kind = i2cm_pkg::KIND_WRITE;
        i2cm_pkg::CMD_WAIT:  push_item.kind = i2cm_pkg::KIND_WAIT;
        i2cm_pkg::CMD_READ:  push_item.kind = i2cm_pkg::KIND_READ;
        default:             push_item.kind = i2cm_pkg::KIND_NONE; // unused codes
      endcase
    end
  end

endmodule

FILE: hw/rtl/i2cm_engine.sv
module i2cm_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  i2cm_pkg::q_status_t                q_status,
  input  i2cm_pkg::item_t                    item,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [i2cm_pkg::OUT_DATA_W-1:0]    out_tdata
);

  logic [13:0]      ticks_r;
  logic [7:0]       timeout_r;

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [15:0]      dly_r, dly_nxt;
  logic [7:0]       poll_r, poll_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             ack_pend_r, ack_pend_nxt;
  logic             fail_r, fail_nxt;
  logic [7:0]       rx_r, rx_nxt;
  logic             done;

  logic             out_valid_r;
  logic [i2cm_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [15:0]      target;
  logic [15:0]      dly_inc;
  logic [3:0]       bit_inc;

  assign pop        = !q_status.empty && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r   <= i2cm_pkg::TICKS_RESET;
      timeout_r <= i2cm_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        i2cm_pkg::REG_TICKS_PER_UNIT: ticks_r   <= cfg_wdata[13:0];
        i2cm_pkg::REG_ACK_TIMEOUT:    timeout_r <= cfg_wdata[7:0];
      endcase
    end
  end

  // Phase length: 4, 2 or 1 units, as a shift of the tick count
  always_comb begin
    unique case (phase_r)
      i2cm_pkg::PH_ST_A, i2cm_pkg::PH_ST_B, i2cm_pkg::PH_SP_A, i2cm_pkg::PH_SP_B,
      i2cm_pkg::PH_TO_A, i2cm_pkg::PH_TO_B:
        target = {ticks_r, 2'b00};
      i2cm_pkg::PH_WR_SET, i2cm_pkg::PH_WR_HI, i2cm_pkg::PH_WR_LO,
      i2cm_pkg::PH_RD_LO, i2cm_pkg::PH_RK_SET, i2cm_pkg::PH_RK_HI:
        target = {1'b0, ticks_r, 1'b0};
      default:
        target = {2'b00, ticks_r};
    endcase
  end

  assign dly_inc = dly_r + 16'd1;
  assign bit_inc = bit_cnt_r + 4'd1;

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    dly_nxt      = dly_r;
    poll_nxt     = poll_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ack_pend_nxt = ack_pend_r;
    fail_nxt     = fail_r;
    rx_nxt       = rx_r;
    done         = 1'b0;

    unique case (phase_r)
      i2cm_pkg::PH_IDLE: begin
        dly_nxt = 16'd0;
        unique case (item.kind)
          i2cm_pkg::KIND_START: begin
            phase_nxt = i2cm_pkg::PH_ST_A;
            scl_nxt   = 1'b1;
            sda_nxt   = 1'b1;
          end
          i2cm_pkg::KIND_STOP: begin
            phase_nxt = i2cm_pkg::PH_SP_A;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
          end
          i2cm_pkg::KIND_WRITE: begin
            bit_cnt_nxt = 4'd0;
            phase_nxt   = i2cm_pkg::PH_WR_SET;
            scl_nxt     = 1'b0;
            sda_nxt     = item.write_data[7];
            shift_nxt   = {item.write_data[6:0], 1'b0};
          end
          i2cm_pkg::KIND_WAIT: begin
            poll_nxt  = 8'd0;
            fail_nxt  = 1'b0;
            phase_nxt = i2cm_pkg::PH_WA_REL;
            sda_nxt   = 1'b1;
          end
          i2cm_pkg::KIND_READ: begin
            bit_cnt_nxt  = 4'd0;
            shift_nxt    = 8'd0;
            ack_pend_nxt = item.send_ack;
            phase_nxt    = i2cm_pkg::PH_RD_LO;
            scl_nxt      = 1'b0;
            sda_nxt      = 1'b1;
          end
          default: ;
        endcase
      end

      i2cm_pkg::PH_WA_POLL: begin
        if (!item.sda_level) begin
          phase_nxt = i2cm_pkg::PH_IDLE;
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b1;
          dly_nxt   = 16'd0;
          done      = 1'b1;
        end else if (poll_r >= timeout_r) begin
          phase_nxt = i2cm_pkg::PH_TO_A;
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          dly_nxt   = 16'd0;
        end else begin
          poll_nxt = poll_r + 8'd1;
        end
      end

      default: begin
        if (dly_inc < target) begin
          dly_nxt = dly_inc;
        end else begin
          dly_nxt = 16'd0;
          unique case (phase_r)
            i2cm_pkg::PH_ST_A: begin
              phase_nxt = i2cm_pkg::PH_ST_B;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b0;
            end
            i2cm_pkg::PH_ST_B: begin
              phase_nxt = i2cm_pkg::PH_IDLE;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
              done      = 1'b1;
            end
            i2cm_pkg::PH_SP_A, i2cm_pkg::PH_TO_A: begin
              phase_nxt = (phase_r == i2cm_pkg::PH_SP_A) ? i2cm_pkg::PH_SP_B
                                                          : i2cm_pkg::PH_TO_B;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
            i2cm_pkg::PH_SP_B, i2cm_pkg::PH_TO_B: begin
              phase_nxt = i2cm_pkg::PH_IDLE;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
              done      = 1'b1;
              if (phase_r == i2cm_pkg::PH_TO_B) begin
                fail_nxt = 1'b1;
              end
            end
            i2cm_pkg::PH_WR_SET: begin
              phase_nxt = i2cm_pkg::PH_WR_HI;
              scl_nxt   = 1'b1;
            end
            i2cm_pkg::PH_WR_HI: begin
              phase_nxt = i2cm_pkg::PH_WR_LO;
              scl_nxt   = 1'b0;
            end
            i2cm_pkg::PH_WR_LO: begin
              bit_cnt_nxt = bit_inc;
              scl_nxt     = 1'b0;
              if (bit_inc >= 4'd8) begin
                phase_nxt = i2cm_pkg::PH_IDLE;
                done      = 1'b1;
              end else begin
                phase_nxt = i2cm_pkg::PH_WR_SET;
                sda_nxt   = shift_r[7];
                shift_nxt = {shift_r[6:0], 1'b0};
              end
            end
            i2cm_pkg::PH_WA_REL: begin
              phase_nxt = i2cm_pkg::PH_WA_HI;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
            i2cm_pkg::PH_WA_HI: begin
              phase_nxt = i2cm_pkg::PH_WA_POLL;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end
            i2cm_pkg::PH_RD_LO: begin
              // sample on the rising SCL edge
              phase_nxt = i2cm_pkg::PH_RD_HI;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], item.sda_level};
            end
            i2cm_pkg::PH_RD_HI: begin
              bit_cnt_nxt = bit_inc;
              scl_nxt     = 1'b0;
              if (bit_inc >= 4'd8) begin
                rx_nxt    = shift_r;
                phase_nxt = i2cm_pkg::PH_RK_SET;
                sda_nxt   = !ack_pend_r;
              end else begin
                phase_nxt = i2cm_pkg::PH_RD_LO;
                sda_nxt   = 1'b1;
              end
            end
            i2cm_pkg::PH_RK_SET: begin
              phase_nxt = i2cm_pkg::PH_RK_HI;
              scl_nxt   = 1'b1;
            end
            i2cm_pkg::PH_RK_HI: begin
              phase_nxt = i2cm_pkg::PH_IDLE;
              scl_nxt   = 1'b0;
              done      = 1'b1;
            end
            default: begin
              phase_nxt = i2cm_pkg::PH_IDLE;
              done      = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2cm_pkg::PH_IDLE;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      dly_r      <= 16'd0;
      poll_r     <= 8'd0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_pend_r <= 1'b0;
      fail_r     <= 1'b0;
      rx_r       <= 8'd0;
    end else if (pop) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      dly_r      <= dly_nxt;
      poll_r     <= poll_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_pend_r <= ack_pend_nxt;
      fail_r     <= fail_nxt;
      rx_r       <= rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= {3'b000, fail_nxt, rx_nxt, done,
                     (phase_nxt != i2cm_pkg::PH_IDLE), sda_nxt, scl_nxt};
    end
  end

endmodule

FILE: hw/rtl/i2c_master_byte_engine_top.sv
// I2C master bit engine. Every input beat is one tick of bus time and yields exactly one
// output beat showing SCL, SDA release, busy, done, the last byte read and the ack-failure
// flag after that tick. Commands (start, stop, write byte, wait ack, read byte) are taken
// only while idle; others are dropped. Phase lengths are multiples of ticks_per_unit.
// Throughput is one beat per cycle while the output is not stalled; each result passes
// through the queue and then the engine's output register. A small queue (QUEUE_DEPTH
// beats) between decoder and engine plus the output register absorb back-pressure.
// Configuration must be written by the user only while idle; the block does not enforce it.
module i2c_master_byte_engine_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tdata: write_data[7:0], send_ack[8], sda_level[9], zero pad [15:10]
  input  logic [i2cm_pkg::IN_DATA_W-1:0]     in_tdata,
  // tuser: cmd_valid[0], command[3:1]
  input  logic [i2cm_pkg::IN_USER_W-1:0]     in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: scl_level[0], sda_release[1], busy_res[2], done_res[3], read_data[11:4],
  //        ack_failed[12], zero pad [15:13]
  output logic [i2cm_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  i2cm_pkg::q_status_t q_status;
  i2cm_pkg::item_t     push_item, pop_item;
  logic                push, pop;

  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  i2cm_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .q_status   (q_status),
    .item       (pop_item),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: hw/rtl/i2cm_checker.sv
`include "assert_macros.svh"

module i2cm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [i2cm_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a finishing tick always leaves the engine idle
  `ASSERT_IMP(a_done_idle, clk, rst_n, out_tvalid && out_tdata[3], !out_tdata[2])

  // input back-pressure only once a result is waiting
  `ASSERT_IMP(a_stall_cause, clk, rst_n, !in_tready, out_tvalid)

  // pad bits stay zero
  `ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[15:13] == 3'b000)

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
